// File: rtl/core/uvc_pkg.sv
// Shared types, constants and helpers for the unique-values-with-counts core.
`default_nettype none
package uvc_pkg;

  localparam int unsigned DEF_MAX_UNIQUE = 32;
  localparam int unsigned DEF_HASH_SLOTS = 64;
  localparam int unsigned DEF_COUNT_BITS = 16;

  localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

  localparam logic KIND_POSITION = 1'b0;
  localparam logic KIND_READOUT  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [4:0]  position;
    logic [31:0] bits;
    logic [15:0] occ;
    logic        ovf;
    logic        last;
  } out_item_t;

  function automatic logic is_nan(input logic [31:0] b);
    is_nan = (b[30:0] > 31'h7F80_0000);
  endfunction

  function automatic logic ieee_equal(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) begin
      ieee_equal = 1'b0;
    end else begin
      ieee_equal = (a == b) || ((a[30:0] | b[30:0]) == 31'd0);
    end
  endfunction

  function automatic logic [31:0] fold_zero(input logic [31:0] b);
    fold_zero = (b[30:0] == 31'd0) ? 32'd0 : b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/uvc_hash.sv
// Home-slot hash unit: multiply, mix, then reduce modulo the slot count.
`default_nettype none
module uvc_hash
  import uvc_pkg::*;
#(
  parameter int unsigned HASH_SLOTS = DEF_HASH_SLOTS,
  localparam int unsigned SW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [31:0]   key,
  output logic               done,
  output logic [SW-1:0]      slot
);

  localparam logic HS_POW2 = ((HASH_SLOTS & (HASH_SLOTS - 1)) == 0);
  localparam logic [63:0] HS64     = 64'(HASH_SLOTS);
  localparam logic [63:0] RECIP    = ((64'd1 << (32 + SW)) + HS64 - 64'd1) / HS64;
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [16:0] RECIP_HI = RECIP[32:16];
  localparam logic [31:0] HS32     = 32'(HASH_SLOTS);

  localparam logic [2:0] H_IDLE = 3'd0;
  localparam logic [2:0] H_MUL  = 3'd1;
  localparam logic [2:0] H_MIX  = 3'd2;
  localparam logic [2:0] H_RLO  = 3'd3;
  localparam logic [2:0] H_RHI  = 3'd4;
  localparam logic [2:0] H_REM  = 3'd5;

  logic [2:0]    st_r, st_nxt;
  logic [31:0]   k_r, k_nxt;
  logic [31:0]   prod_r, prod_nxt;
  logic [31:0]   h_r, h_nxt;
  logic [47:0]   plo_r, plo_nxt;
  logic [64:0]   acc_r, acc_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   mix;
  logic [31:0]   quo;
  logic [31:0]   rem;

  assign mix = prod_r ^ (k_r >> 15);
  assign quo = 32'(acc_r >> (32 + SW));
  assign rem = h_r - quo * HS32;

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    prod_nxt = prod_r;
    h_nxt    = h_r;
    plo_nxt  = plo_r;
    acc_nxt  = acc_r;
    slot_nxt = slot_r;
    done_nxt = 1'b0;
    unique case (st_r)
      H_IDLE: begin
        if (start) begin
          k_nxt  = fold_zero(key);
          st_nxt = H_MUL;
        end
      end
      H_MUL: begin
        prod_nxt = k_r * HASH_MULT;
        st_nxt   = H_MIX;
      end
      H_MIX: begin
        if (HS_POW2) begin
          slot_nxt = mix[SW-1:0];
          done_nxt = 1'b1;
          st_nxt   = H_IDLE;
        end else begin
          h_nxt  = mix;
          st_nxt = H_RLO;
        end
      end
      H_RLO: begin
        plo_nxt = 48'(h_r) * 48'(RECIP_LO);
        st_nxt  = H_RHI;
      end
      H_RHI: begin
        acc_nxt = ((65'(h_r) * 65'(RECIP_HI)) << 16) + 65'(plo_r);
        st_nxt  = H_REM;
      end
      H_REM: begin
        slot_nxt = rem[SW-1:0];
        done_nxt = 1'b1;
        st_nxt   = H_IDLE;
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= H_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    h_r    <= h_nxt;
    plo_r  <= plo_nxt;
    acc_r  <= acc_nxt;
    slot_r <= slot_nxt;
  end

  assign done = done_r;
  assign slot = slot_r;

endmodule
`default_nettype wire

// File: rtl/core/uvc_out_reg.sv
// Output register stage for result transfers.
`default_nettype none
module uvc_out_reg
  import uvc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire out_item_t   item,
  output logic             free,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  output logic             out_tuser,
  output logic             out_tlast
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, item_r.ovf, item_r.occ, item_r.bits, item_r.position};
  assign out_tuser  = item_r.kind;
  assign out_tlast  = item_r.last;

endmodule
`default_nettype wire

// File: rtl/core/unique_values_with_counts_core.sv
// Top level: distinct-value table with first-seen positions and counts.
// Usage:
//   Input channel in_*: one float (raw bits) per transfer, in_tlast ends a set.
//   Output channel out_*: one position result (out_tuser = 0) per input
//   transfer; after the last input, one readout (out_tuser = 1) per distinct
//   value in position order, the final one with out_tlast set.
// Timing: one item at a time. After the accepting edge, the hash unit multiplies
//   and mixes, then reduces by masking for a power-of-two slot count or by a
//   reciprocal multiply otherwise. Each probe of the slot table reads the slot
//   memory, reads the entry memory and compares, skipping the last two when the
//   slot turns out free; a new value is then recorded, and the position result
//   is handed to the output register. The next input is taken once that result
//   sits in the output register. Readout walks the entry memory, reading each
//   entry and then handing it to the output register.
// Reset: clears the table (distinct count and overflow flag); no memory sweep
//   is needed since a slot is live only when its entry points back to it.
// Stall: a full output register holds the block in place until the receiver
//   takes the transfer; no result is dropped.
`default_nettype none
module unique_values_with_counts_core
  import uvc_pkg::*;
#(
  parameter int unsigned MAX_UNIQUE = DEF_MAX_UNIQUE,
  parameter int unsigned HASH_SLOTS = DEF_HASH_SLOTS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value_bits
  input  wire logic        in_tlast,   // last_element
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // position, unique_bits, occurrences, table_overflow
  output logic             out_tuser,  // result_kind
  output logic             out_tlast   // last_result
);

  localparam int unsigned PW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
  localparam int unsigned TW = $clog2(MAX_UNIQUE + 1);
  localparam int unsigned SW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
  localparam int unsigned EW = 32 + SW + COUNT_BITS;
  localparam logic [TW-1:0] MAX_W = TW'(MAX_UNIQUE);
  localparam logic [SW-1:0] LAST_SLOT = SW'(HASH_SLOTS - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HASH   = 4'd1;
  localparam logic [3:0] S_SREAD  = 4'd2;
  localparam logic [3:0] S_SCHK   = 4'd3;
  localparam logic [3:0] S_ECHK   = 4'd4;
  localparam logic [3:0] S_INSERT = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_RREAD  = 4'd7;
  localparam logic [3:0] S_ROUT   = 4'd8;

  logic [3:0]    st_r, st_nxt;
  logic [31:0]   v_r, v_nxt;
  logic          last_r, last_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [SW-1:0] probe_r, probe_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          ovf_r, ovf_nxt;
  logic [TW-1:0] i_r, i_nxt;

  logic [PW-1:0] slot_mem [HASH_SLOTS];
  logic [PW-1:0] slot_rdata_r;
  logic          slot_re, slot_we;
  logic [EW-1:0] ent_mem [MAX_UNIQUE];
  logic [EW-1:0] ent_rdata_r;
  logic          ent_re, ent_we;
  logic [PW-1:0] ent_raddr, ent_waddr;
  logic [EW-1:0] ent_wdata;

  logic [31:0]           ent_val;
  logic [SW-1:0]         ent_slot;
  logic [COUNT_BITS-1:0] ent_cnt;

  logic          hash_start, hash_done;
  logic [SW-1:0] hash_slot;

  logic      out_free, out_load;
  out_item_t out_item;

  assign {ent_val, ent_slot, ent_cnt} = ent_rdata_r;
  assign in_tready  = (st_r == S_IDLE);
  assign hash_start = in_tvalid && in_tready;

  uvc_hash #(.HASH_SLOTS(HASH_SLOTS)) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_tdata),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  always_comb begin
    st_nxt    = st_r;
    v_nxt     = v_r;
    last_nxt  = last_r;
    s_nxt     = s_r;
    probe_nxt = probe_r;
    p_nxt     = p_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    slot_re   = 1'b0;
    slot_we   = 1'b0;
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_raddr = p_r;
    ent_waddr = p_r;
    ent_wdata = {ent_val, ent_slot, (ent_cnt == CNT_MAX) ? ent_cnt : ent_cnt + 1'b1};
    out_load  = 1'b0;
    out_item  = '0;
    unique case (st_r)
      S_IDLE: begin
        if (hash_start) begin
          v_nxt    = in_tdata;
          last_nxt = in_tlast;
          st_nxt   = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          s_nxt     = hash_slot;
          probe_nxt = '0;
          st_nxt    = S_SREAD;
        end
      end
      S_SREAD: begin
        slot_re = 1'b1;
        st_nxt  = S_SCHK;
      end
      S_SCHK: begin
        if (TW'(slot_rdata_r) < total_r) begin
          ent_re    = 1'b1;
          ent_raddr = slot_rdata_r;
          p_nxt     = slot_rdata_r;
          st_nxt    = S_ECHK;
        end else begin
          st_nxt = S_INSERT;
        end
      end
      S_ECHK: begin
        if (ent_slot != s_r) begin
          st_nxt = S_INSERT;
        end else if (ieee_equal(ent_val, v_r)) begin
          ent_we  = 1'b1;
          pos_nxt = p_r;
          st_nxt  = S_EMIT;
        end else if (probe_r == LAST_SLOT) begin
          ovf_nxt = 1'b1;
          pos_nxt = '0;
          st_nxt  = S_EMIT;
        end else begin
          probe_nxt = probe_r + 1'b1;
          s_nxt     = (s_r == LAST_SLOT) ? '0 : s_r + 1'b1;
          st_nxt    = S_SREAD;
        end
      end
      S_INSERT: begin
        if (total_r < MAX_W) begin
          slot_we   = 1'b1;
          ent_we    = 1'b1;
          ent_waddr = total_r[PW-1:0];
          ent_wdata = {v_r, s_r, COUNT_BITS'(1)};
          pos_nxt   = total_r[PW-1:0];
          total_nxt = total_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
          pos_nxt = '0;
        end
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item.kind     = KIND_POSITION;
          out_item.position = 5'(pos_r);
          out_item.ovf      = ovf_r;
          i_nxt             = '0;
          st_nxt            = last_r ? S_RREAD : S_IDLE;
        end
      end
      S_RREAD: begin
        ent_re    = 1'b1;
        ent_raddr = i_r[PW-1:0];
        st_nxt    = S_ROUT;
      end
      S_ROUT: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_item.kind     = KIND_READOUT;
          out_item.position = 5'(i_r);
          out_item.bits     = ent_val;
          out_item.occ      = 16'(ent_cnt);
          out_item.ovf      = ovf_r;
          out_item.last     = (i_r + 1'b1 == total_r);
          if (out_item.last) begin
            total_nxt = '0;
            ovf_nxt   = 1'b0;
            st_nxt    = S_IDLE;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_RREAD;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[s_r] <= total_r[PW-1:0];
    end
    if (slot_re) begin
      slot_rdata_r <= slot_mem[s_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      total_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
    end
    v_r     <= v_nxt;
    last_r  <= last_nxt;
    s_r     <= s_nxt;
    probe_r <= probe_nxt;
    p_r     <= p_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
  end

  uvc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .item       (out_item),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= MAX_W)
    else $error("distinct count above table size");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_tvalid |-> out_tready)
    else $error("result register overwritten while held");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    slot_we |-> (st_r == S_INSERT) && (total_r < MAX_W))
    else $error("insert with full table");
`endif

endmodule
`default_nettype wire

// File: sim/uvc_checker.sv
// Checker: predicts the distinct-value table results and compares each output transfer.
`default_nettype none
module uvc_checker
  import uvc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [55:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        out_tlast,
  output int               fail_count,
  output int               pending_count,
  output int               readout_seen,
  output int               overflow_seen
);

  localparam int unsigned NUM_ENTRIES = DEF_MAX_UNIQUE;
  localparam int unsigned NUM_SLOTS   = DEF_HASH_SLOTS;
  localparam logic [15:0] COUNT_TOP   = 16'hFFFF;

  logic [31:0] tbl_value [NUM_ENTRIES];
  logic [15:0] tbl_count [NUM_ENTRIES];
  logic [4:0]  slot_pos  [NUM_SLOTS];
  logic        slot_live [NUM_SLOTS];
  int unsigned distinct_total;
  logic        ovf_flag;
  out_item_t   expected_results [$];

  function automatic logic float_nan(input logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic float_match(input logic [31:0] a, input logic [31:0] b);
    if (float_nan(a) || float_nan(b)) return 1'b0;
    return (a == b) || ((a[30:0] | b[30:0]) == 31'd0);
  endfunction

  function automatic int unsigned home_of(input logic [31:0] b);
    logic [31:0] k;
    logic [31:0] h;
    k = (b[30:0] == 31'd0) ? 32'd0 : b;
    h = (k * 32'd2654435761) ^ (k >> 15);
    return h % NUM_SLOTS;
  endfunction

  task automatic predict_value(input logic [31:0] v, input logic last_in);
    int unsigned home;
    int unsigned s;
    int unsigned p;
    int unsigned free_slot;
    logic        found;
    logic        have_free;
    out_item_t   r;
    home = home_of(v);
    found = 0;
    have_free = 0;
    free_slot = 0;
    p = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      s = (home + i) % NUM_SLOTS;
      if (!slot_live[s]) begin
        have_free = 1;
        free_slot = s;
        break;
      end
      if (slot_pos[s] < distinct_total && float_match(tbl_value[slot_pos[s]], v)) begin
        found = 1;
        p = slot_pos[s];
        break;
      end
    end
    if (found) begin
      if (tbl_count[p] != COUNT_TOP) tbl_count[p]++;
    end else if (have_free && distinct_total < NUM_ENTRIES) begin
      p = distinct_total;
      tbl_value[p] = v;
      tbl_count[p] = 16'd1;
      slot_live[free_slot] = 1;
      slot_pos[free_slot] = p[4:0];
      distinct_total++;
    end else begin
      ovf_flag = 1;
      p = 0;
    end
    r = '{kind: KIND_POSITION, position: p[4:0], bits: 32'd0, occ: 16'd0,
          ovf: ovf_flag, last: 1'b0};
    expected_results.push_back(r);
    if (last_in) begin
      for (int i = 0; i < distinct_total; i++) begin
        r = '{kind: KIND_READOUT, position: i[4:0], bits: tbl_value[i], occ: tbl_count[i],
              ovf: ovf_flag, last: (i + 1 == distinct_total)};
        expected_results.push_back(r);
      end
      for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 0;
      distinct_total = 0;
      ovf_flag = 0;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) slot_live[i] = 0;
      distinct_total = 0;
      ovf_flag = 0;
      expected_results.delete();
      fail_count <= 0;
      pending_count <= 0;
      readout_seen <= 0;
      overflow_seen <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{kind: out_tuser, position: out_tdata[4:0], bits: out_tdata[36:5],
                occ: out_tdata[52:37], ovf: out_tdata[53], last: out_tlast};
        if (got.kind == KIND_READOUT) readout_seen <= readout_seen + 1;
        if (got.ovf) overflow_seen <= overflow_seen + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer kind=%0d pos=%0d", got.kind, got.position);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (want.kind != got.kind)
              $error("result_kind exp %0d got %0d", want.kind, got.kind);
            if (want.position != got.position)
              $error("position exp %0d got %0d", want.position, got.position);
            if (want.bits != got.bits)
              $error("unique_bits exp %h got %h", want.bits, got.bits);
            if (want.occ != got.occ)
              $error("occurrences exp %0d got %0d", want.occ, got.occ);
            if (want.ovf != got.ovf)
              $error("table_overflow exp %0d got %0d", want.ovf, got.ovf);
            if (want.last != got.last)
              $error("last_result exp %0d got %0d", want.last, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) predict_value(in_tdata, in_tlast);
      pending_count <= expected_results.size();
    end
  end

endmodule
`default_nettype wire

// File: sim/tb_unique_values_with_counts_core.sv
// Testbench top: drives float sets into the core, applies backpressure and reports the verdict.
`default_nettype none
module tb_unique_values_with_counts_core;
  import uvc_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          readout_seen;
  int          overflow_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        recv_hold = 0;
  int          items_sent = 0;
  int          sets_sent = 0;

  always #1 clk = ~clk;

  unique_values_with_counts_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  uvc_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count),
    .readout_seen(readout_seen), .overflow_seen(overflow_seen)
  );

  always @(negedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_value(input logic [31:0] v, input logic last_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= v;
    in_tlast <= last_in;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (last_in) sets_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_float(input logic [31:0] pool [8]);
    case ($urandom_range(5))
      0: return $urandom();
      1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(3))};
      2: return {1'($urandom_range(1)), 31'd0};
      default: return pool[$urandom_range(7)];
    endcase
  endfunction

  task automatic random_set(input int len, input logic [31:0] pool [8]);
    for (int i = 0; i < len; i++) send_value(random_float(pool), i == len - 1);
  endtask

  task automatic random_phase(input int n_items);
    logic [31:0] pool [8];
    int len;
    int done;
    done = 0;
    while (done < n_items) begin
      for (int k = 0; k < 8; k++) pool[k] = $urandom();
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
      random_set(len, pool);
      done += len;
    end
  endtask

  initial begin
    logic [31:0] pool [8];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_value(32'h0000_0000, 0);
    send_value(32'h8000_0000, 0);
    send_value(32'h7FC0_0000, 0);
    send_value(32'h7FC0_0000, 0);
    send_value(32'h7F80_0000, 0);
    send_value(32'hFF80_0000, 0);
    send_value(32'hFFFF_FFFF, 0);
    send_value(32'h3F80_0000, 0);
    send_value(32'h3F80_0000, 1);
    send_value(32'h8000_0000, 0);
    send_value(32'h0000_0000, 1);
    for (int i = 0; i < 34; i++) send_value(32'h4000_0000 + i, i == 33);
    drain_results();

    send_idle_pct = 36;
    recv_idle_pct = 61;
    random_phase(150);
    send_idle_pct = 61;
    recv_idle_pct = 36;
    random_phase(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(120);

    fork
      begin
        recv_hold = 1;
        repeat (300) @(negedge clk);
        recv_hold = 0;
      end
      begin
        for (int k = 0; k < 8; k++) pool[k] = $urandom();
        random_set(12, pool);
        in_tvalid <= 0;
      end
    join
    drain_results();

    repeat (200) @(negedge clk);
    $display("Sent %0d values in %0d sets; %0d readouts, %0d results with overflow set.",
             items_sent, sets_sent, readout_seen, overflow_seen);
    $display("Covered signed zeros, NaNs, infinities, table overflow and a long output stall.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
